[rtl/packed_tile_map_store_macros.svh]
// assertion helpers
`ifndef PACKED_TILE_MAP_STORE_MACROS_SVH
`define PACKED_TILE_MAP_STORE_MACROS_SVH

`define PTMS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`define PTMS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ptms_pkg.sv]
package ptms_pkg;

   localparam int MAP_BYTES  = 8192;
   localparam int MAX_SIDE   = 128;
   localparam int BANK_DEPTH = MAP_BYTES / 2;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);
   localparam int OFF_W      = $clog2(MAX_SIDE * MAX_SIDE * 3);
   localparam int BYTE_W     = OFF_W - 3;

   localparam logic [7:0] WIDTH_RESET  = 8'd80;
   localparam logic [7:0] HEIGHT_RESET = 8'd80;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_QUERY = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      REG_MAP_WIDTH  = 1'b0,
      REG_MAP_HEIGHT = 1'b1
   } reg_idx_type;

   typedef struct packed {
      logic               en;
      logic [BANK_AW-1:0] idx;
      logic [7:0]         data;
   } bank_wr_type;

   function automatic logic [3:0] code_bits(input logic [2:0] code);
      logic [3:0] r;
      unique case (code)
         3'd0:    r = 4'h1;
         3'd1:    r = 4'h2;
         3'd2:    r = 4'h4;
         3'd3:    r = 4'h8;
         default: r = 4'h0;
      endcase
      return r;
   endfunction

endpackage

[rtl/ptms_if.sv]
interface ptms_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] col;
   logic [7:0] row;
   logic [2:0] tile_in;
   logic [3:0] type_mask;
   logic       use_diagonals;

   modport source (output valid, op, col, row, tile_in, type_mask, use_diagonals,
                   input ready);
   modport sink (input valid, op, col, row, tile_in, type_mask, use_diagonals,
                 output ready);
endinterface

interface ptms_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] tile_out;
   logic       hit;
   logic       inside_res;

   modport source (output valid, tile_out, hit, inside_res, input ready);
   modport sink (input valid, tile_out, hit, inside_res, output ready);
endinterface

[rtl/ptms_bank.sv]
module ptms_bank (
   input  logic                          clock,
   input  ptms_pkg::bank_wr_type         wr,
   input  logic [ptms_pkg::BANK_AW-1:0]  rd_idx,
   output logic [7:0]                    rd_data
);
   import ptms_pkg::*;

   logic [7:0] mem [BANK_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/packed_tile_map_store.sv]
// Tile map store: 3-bit tiles packed in two byte banks (even and odd bytes), so a tile
// that straddles a byte boundary is read and written in one access. Read and write step
// through accept, address multiply, bank read, modify/write and result. A neighbor
// query visits 4 or 8 neighbors, stopping at the first match; out-of-map neighbors are
// skipped without a bank read. Clear zeroes the bytes in use, two bytes per cycle across
// the banks. After reset a sweep zeroes memory before the first word is accepted;
// register writes are taken at any time. A finished result waits in an output
// register.
module packed_tile_map_store (
   input  logic        clock,
   input  logic        reset,
   ptms_req_if.sink    req,
   ptms_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [0:0]  csr_idx,
   input  logic [7:0]  csr_wdata
);
   import ptms_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_ADDR = 6'b000010,
      S_READ = 6'b000100,
      S_DATA = 6'b001000,
      S_CLR  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [7:0]         width_ff, width_in, height_ff, height_in;
   op_type             op_ff, op_in;
   logic [7:0]         col_ff, col_in, row_ff, row_in;
   logic [2:0]         tile_ff, tile_in;
   logic [3:0]         mask_ff, mask_in;
   logic               diag_ff, diag_in, inside_ff, inside_in;
   logic [2:0]         nb_ff, nb_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [2:0]         pos_ff, pos_in;
   logic               aodd_ff, aodd_in, look_ff, look_in, hiok_ff, hiok_in;
   logic [BANK_AW-1:0] evidx_ff, evidx_in, odidx_ff, odidx_in;
   logic               hit_ff, hit_in;
   logic [2:0]         tout_ff, tout_in;
   logic [BANK_AW-1:0] clr_ff, clr_in;
   logic               init_ff, init_in;
   logic               rvalid_ff, rvalid_in, rhit_ff, rhit_in, rins_ff, rins_in;
   logic [2:0]         rtile_ff, rtile_in;

   logic [7:0]  ew, eh;
   logic        cn, cp, rn, rp, nbok, last_nb;
   logic [8:0]  nc9, nr9;
   logic [7:0]  mc, mr;
   logic [15:0] prod;
   logic [17:0] sum, sum3;
   logic [31:0] a32, lim32, k32;
   logic [7:0]  ev_q, od_q, lo_b, hi_b;
   logic [15:0] word, nword;
   logic [2:0]  tval;
   logic        lo_we, hi_we, accept, load;
   bank_wr_type ev_wr, od_wr;

   assign ew = (width_ff > 8'(MAX_SIDE)) ? 8'(MAX_SIDE) : width_ff;
   assign eh = (height_ff > 8'(MAX_SIDE)) ? 8'(MAX_SIDE) : height_ff;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign load      = (state_ff == S_DONE) && (!rvalid_ff || rsp.ready);

   always_comb begin
      cn = 1'b0; cp = 1'b0; rn = 1'b0; rp = 1'b0;
      if (op_ff == OP_QUERY) begin
         unique case (nb_ff)
            3'd0: rn = 1'b1;
            3'd1: rp = 1'b1;
            3'd2: cp = 1'b1;
            3'd3: cn = 1'b1;
            3'd4: begin cn = 1'b1; rn = 1'b1; end
            3'd5: begin cp = 1'b1; rn = 1'b1; end
            3'd6: begin cn = 1'b1; rp = 1'b1; end
            default: begin cp = 1'b1; rp = 1'b1; end
         endcase
      end
   end

   assign nc9  = {1'b0, col_ff} + (cp ? 9'd1 : (cn ? 9'h1FF : 9'd0));
   assign nr9  = {1'b0, row_ff} + (rp ? 9'd1 : (rn ? 9'h1FF : 9'd0));
   assign nbok = inside_ff && !(cn && col_ff == 8'd0) && !(rn && row_ff == 8'd0)
                 && (nc9 < {1'b0, ew}) && (nr9 < {1'b0, eh});
   assign mr   = (op_ff == OP_CLEAR) ? eh : nr9[7:0];
   assign mc   = (op_ff == OP_CLEAR) ? 8'd0 : nc9[7:0];
   assign prod = mr * ew;
   assign sum  = 18'(prod) + 18'(mc);
   assign sum3 = (sum << 1) + sum;
   assign last_nb = diag_ff ? (nb_ff == 3'd7) : (nb_ff == 3'd3);

   assign a32 = 32'(off_ff[OFF_W-1:3]);

   assign lo_b  = look_ff ? (aodd_ff ? od_q : ev_q) : 8'd0;
   assign hi_b  = hiok_ff ? (aodd_ff ? ev_q : od_q) : 8'd0;
   assign word  = {hi_b, lo_b};
   assign tval  = 3'(word >> pos_ff);
   assign nword = (word & ~(16'h7 << pos_ff)) | (16'(tile_ff) << pos_ff);

   assign lim32 = init_ff ? 32'(MAP_BYTES)
                : (((32'(off_ff) + 32'd7) >> 3) > 32'(MAP_BYTES)) ? 32'(MAP_BYTES)
                : ((32'(off_ff) + 32'd7) >> 3);
   assign k32   = 32'(clr_ff) << 1;

   assign lo_we = (state_ff == S_DATA) && (op_ff == OP_WRITE) && look_ff;
   assign hi_we = (state_ff == S_DATA) && (op_ff == OP_WRITE) && hiok_ff && (pos_ff > 3'd5);

   always_comb begin
      ev_wr = '{en: 1'b0, idx: evidx_ff, data: 8'd0};
      od_wr = '{en: 1'b0, idx: odidx_ff, data: 8'd0};
      if (state_ff == S_CLR) begin
         ev_wr = '{en: (k32 < lim32), idx: clr_ff, data: 8'd0};
         od_wr = '{en: ((k32 + 32'd1) < lim32), idx: clr_ff, data: 8'd0};
      end else begin
         ev_wr.en   = aodd_ff ? hi_we : lo_we;
         ev_wr.data = aodd_ff ? nword[15:8] : nword[7:0];
         od_wr.en   = aodd_ff ? lo_we : hi_we;
         od_wr.data = aodd_ff ? nword[7:0] : nword[15:8];
      end
   end

   ptms_bank u_even (
      .clock   (clock),
      .wr      (ev_wr),
      .rd_idx  (BANK_AW'((a32 + 32'd1) >> 1)),
      .rd_data (ev_q)
   );

   ptms_bank u_odd (
      .clock   (clock),
      .wr      (od_wr),
      .rd_idx  (BANK_AW'(a32 >> 1)),
      .rd_data (od_q)
   );

   always_comb begin
      state_in  = state_ff;
      width_in  = width_ff;
      height_in = height_ff;
      op_in     = op_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      tile_in   = tile_ff;
      mask_in   = mask_ff;
      diag_in   = diag_ff;
      inside_in = inside_ff;
      nb_in     = nb_ff;
      off_in    = off_ff;
      pos_in    = pos_ff;
      aodd_in   = aodd_ff;
      look_in   = look_ff;
      hiok_in   = hiok_ff;
      evidx_in  = evidx_ff;
      odidx_in  = odidx_ff;
      hit_in    = hit_ff;
      tout_in   = tout_ff;
      clr_in    = clr_ff;
      init_in   = init_ff;
      rvalid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : rvalid_ff);
      rtile_in  = load ? tout_ff : rtile_ff;
      rhit_in   = load ? hit_ff : rhit_ff;
      rins_in   = load ? inside_ff : rins_ff;

      if (csr_we) begin
         unique case (reg_idx_type'(csr_idx))
            REG_MAP_WIDTH:  width_in  = csr_wdata;
            REG_MAP_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = op_type'(req.op);
               col_in    = req.col;
               row_in    = req.row;
               tile_in   = req.tile_in;
               mask_in   = req.type_mask;
               diag_in   = req.use_diagonals;
               inside_in = (req.col < ew) && (req.row < eh);
               nb_in     = 3'd0;
               hit_in    = 1'b0;
               tout_in   = 3'd0;
               state_in  = S_ADDR;
            end
         end
         S_ADDR: begin
            off_in = OFF_W'(sum3);
            if (op_ff == OP_CLEAR) begin
               clr_in   = '0;
               state_in = S_CLR;
            end else if (op_ff == OP_QUERY && !inside_ff) begin
               state_in = S_DONE;
            end else if (nbok) begin
               state_in = S_READ;
            end else if (op_ff != OP_QUERY || last_nb) begin
               state_in = S_DONE;
            end else begin
               nb_in = nb_ff + 3'd1;
            end
         end
         S_READ: begin
            pos_in   = off_ff[2:0];
            aodd_in  = a32[0];
            look_in  = a32 < 32'(MAP_BYTES);
            hiok_in  = (a32 + 32'd1) < 32'(MAP_BYTES);
            evidx_in = BANK_AW'((a32 + 32'd1) >> 1);
            odidx_in = BANK_AW'(a32 >> 1);
            state_in = S_DATA;
         end
         S_DATA: begin
            if (op_ff == OP_READ) begin
               tout_in  = tval;
               state_in = S_DONE;
            end else if (op_ff == OP_QUERY) begin
               if ((code_bits(tval) & mask_ff) != 4'd0) begin
                  hit_in   = 1'b1;
                  state_in = S_DONE;
               end else if (last_nb) begin
                  state_in = S_DONE;
               end else begin
                  nb_in    = nb_ff + 3'd1;
                  state_in = S_ADDR;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_CLR: begin
            clr_in = clr_ff + 1'b1;
            if ((k32 + 32'd2) >= lim32) begin
               init_in  = 1'b0;
               state_in = init_ff ? S_IDLE : S_DONE;
            end
         end
         S_DONE: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         clr_ff    <= '0;
         init_ff   <= 1'b1;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         clr_ff    <= clr_in;
         init_ff   <= init_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      tile_ff   <= tile_in;
      mask_ff   <= mask_in;
      diag_ff   <= diag_in;
      inside_ff <= inside_in;
      nb_ff     <= nb_in;
      off_ff    <= off_in;
      pos_ff    <= pos_in;
      aodd_ff   <= aodd_in;
      look_ff   <= look_in;
      hiok_ff   <= hiok_in;
      evidx_ff  <= evidx_in;
      odidx_ff  <= odidx_in;
      hit_ff    <= hit_in;
      tout_ff   <= tout_in;
      rtile_ff  <= rtile_in;
      rhit_ff   <= rhit_in;
      rins_ff   <= rins_in;
   end

   assign rsp.valid      = rvalid_ff;
   assign rsp.tile_out   = rtile_ff;
   assign rsp.hit        = rhit_ff;
   assign rsp.inside_res = rins_ff;
endmodule

[rtl/ptms_checker.sv]
`include "packed_tile_map_store_macros.svh"

module ptms_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_tile_out,
   input logic       rsp_hit,
   input logic       rsp_inside_res
);
   `PTMS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "ready after accept")
   `PTMS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_tile_out) && $stable(rsp_hit), "result dropped")
   `PTMS_ASSERT_NOW(a_out_of_map, rsp_valid && (rsp_hit || rsp_tile_out != 3'd0), rsp_inside_res, "data outside map")
endmodule

bind packed_tile_map_store ptms_checker u_ptms_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_tile_out   (rsp.tile_out),
   .rsp_hit        (rsp.hit),
   .rsp_inside_res (rsp.inside_res)
);
